// ===== hw/rtl/dpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types and constants of the dual period tachometer.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int SCALE_BITS = 32;
    localparam int DIV_STEPS  = SCALE_BITS;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ACT_START       = 3'd0,
        ACT_CAPTURE     = 3'd1,
        ACT_OVERFLOW    = 3'd2,
        ACT_READ_STATUS = 3'd3,
        ACT_READ_SPEED  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_READING = 2'd1,
        ST_DONE    = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;   // input transaction taken this cycle
        logic step;   // one divider iteration
        logic last;   // final divider iteration, commit the speed
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // result register empty or draining this cycle
        logic need_div;  // current input item needs the divider
    } t_sts;

endpackage

// ===== hw/rtl/dpt_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt interfaces
// Valid/ready channels for events, results and the scale register write.
// ----------------------------------------------------------------------------
interface dpt_in_if #(parameter int STAMP_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [2:0]            action;
    logic                  motor;
    logic [STAMP_BITS-1:0] capture_time;

    modport source (output valid, action, motor, capture_time, input ready);
    modport sink   (input valid, action, motor, capture_time, output ready);
endinterface

interface dpt_out_if #(parameter int SPEED_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [SPEED_BITS-1:0] speed;

    modport source (output valid, status, speed, input ready);
    modport sink   (input valid, status, speed, output ready);
endinterface

interface dpt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/dpt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_ctrl
// Sequencer: takes input transactions and runs the serial divider.
// ----------------------------------------------------------------------------
module dpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dpt_pkg::t_sts i_sts,
    output dpt_pkg::t_cmd o_cmd
);
    import dpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                accept;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.load = accept;
    assign o_cmd.step = (r_state == S_DIV);
    assign o_cmd.last = (r_state == S_DIV) && (r_cnt == '0);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.need_div) begin
                    n_state = S_DIV;
                    n_cnt   = CNT_BITS'(DIV_STEPS - 1);
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/dpt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_datapath
// Channel state, restoring divider and result register.
// ----------------------------------------------------------------------------
module dpt_datapath #(
    parameter int STAMP_BITS = 16,
    parameter int SPEED_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dpt_pkg::t_cmd                    i_cmd,
    output dpt_pkg::t_sts                    o_sts,
    input  logic [2:0]                       i_action,
    input  logic                             i_motor,
    input  logic [STAMP_BITS-1:0]            i_capture_time,
    input  logic                             i_cfg_valid,
    input  logic [dpt_pkg::SCALE_BITS-1:0]   i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic [SPEED_BITS-1:0]            o_speed
);
    import dpt_pkg::*;

    localparam int QW = (SPEED_BITS > SCALE_BITS) ? SPEED_BITS : SCALE_BITS;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

    logic [SCALE_BITS-1:0] r_scale;

    logic [STAMP_BITS-1:0] r_first [2];
    logic [STAMP_BITS-1:0] n_first [2];
    logic [1:0]            r_count [2];
    logic [1:0]            n_count [2];
    logic [SPEED_BITS-1:0] r_last  [2];
    logic [SPEED_BITS-1:0] n_last  [2];
    logic [1:0] r_started, n_started;
    logic [1:0] r_done,    n_done;
    logic [1:0] r_ovf,     n_ovf;
    logic [1:0] r_armed,   n_armed;

    // divider
    logic [SCALE_BITS-1:0] r_quo, n_quo;
    logic [STAMP_BITS-1:0] r_rem, n_rem;
    logic [STAMP_BITS-1:0] r_dvs;
    logic                  r_chan;
    logic [STAMP_BITS:0]   trial, diff;
    logic                  ge;
    logic [QW-1:0]         q_ext;
    logic [SPEED_BITS-1:0] q_sat;

    logic [STAMP_BITS-1:0] period;
    logic                  n_need_div;
    logic [SPEED_BITS-1:0] resp_speed;
    t_status               resp_status;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [SPEED_BITS-1:0] r_out_speed;

    assign period = i_capture_time - r_first[i_motor];

    assign trial = {r_rem, r_quo[SCALE_BITS-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};
    assign n_rem = ge ? diff[STAMP_BITS-1:0] : trial[STAMP_BITS-1:0];
    assign n_quo = {r_quo[SCALE_BITS-2:0], ge};
    assign q_ext = QW'(n_quo);
    assign q_sat = (q_ext > QW'(SPEED_MAX)) ? SPEED_MAX : SPEED_BITS'(q_ext);

    always_comb begin
        n_first    = r_first;
        n_count    = r_count;
        n_last     = r_last;
        n_started  = r_started;
        n_done     = r_done;
        n_ovf      = r_ovf;
        n_armed    = r_armed;
        n_need_div = 1'b0;
        resp_speed = '0;

        case (i_action)
            ACT_START: begin
                n_started[i_motor] = 1'b1;
                n_done[i_motor]    = 1'b0;
                n_ovf[i_motor]     = 1'b0;
                n_count[i_motor]   = 2'd0;
                n_armed[i_motor]   = 1'b1;
            end
            ACT_CAPTURE: begin
                if (r_armed[i_motor] && !r_count[i_motor][1]) begin
                    if (r_count[i_motor] == 2'd0) begin
                        n_first[i_motor] = i_capture_time;
                        n_count[i_motor] = 2'd1;
                    end else begin
                        n_count[i_motor] = 2'd2;
                        n_armed[i_motor] = 1'b0;
                        if (!r_ovf[i_motor]) begin
                            if (period == '0) begin
                                n_last[i_motor] = SPEED_MAX;
                                n_done[i_motor] = 1'b1;
                            end else begin
                                // done flag and speed follow when the divider ends
                                n_need_div = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_OVERFLOW: begin
                for (int c = 0; c < 2; c++) begin
                    if (!r_done[c]) begin
                        n_last[c] = '0;
                        n_ovf[c]  = 1'b1;
                        n_done[c] = 1'b1;
                    end
                    n_armed[c] = 1'b0;
                end
            end
            ACT_READ_SPEED: begin
                if (r_started[i_motor] && r_done[i_motor]) begin
                    n_started[i_motor] = 1'b0;
                    n_done[i_motor]    = 1'b0;
                    n_ovf[i_motor]     = 1'b0;
                    resp_speed         = r_last[i_motor];
                end
            end
            default: begin
            end
        endcase

        if (!n_started[i_motor]) begin
            resp_status = ST_STOPPED;
        end else if (n_done[i_motor]) begin
            resp_status = ST_DONE;
        end else begin
            resp_status = ST_READING;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.need_div = n_need_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= '0;
            r_started <= '0;
            r_done    <= '0;
            r_ovf     <= '0;
            r_armed   <= '0;
            r_count   <= '{default: '0};
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_started <= n_started;
                r_done    <= n_done;
                r_ovf     <= n_ovf;
                r_armed   <= n_armed;
                r_count   <= n_count;
            end else if (i_cmd.last) begin
                r_done[r_chan] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first <= n_first;
            r_last  <= n_last;
            r_quo   <= r_scale;
            r_rem   <= '0;
            r_dvs   <= period;
            r_chan  <= i_motor;
        end else if (i_cmd.step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            if (i_cmd.last) begin
                r_last[r_chan] <= q_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load && !n_need_div) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !n_need_div) begin
            r_out_status <= resp_status;
            r_out_speed  <= resp_speed;
        end else if (i_cmd.last) begin
            r_out_status <= r_started[r_chan] ? ST_DONE : ST_STOPPED;
            r_out_speed  <= '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_speed     = r_out_speed;

endmodule

// ===== hw/rtl/dual_period_tachometer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_period_tachometer
// Two-channel input-capture tachometer: speed = scale / stamp period.
// ----------------------------------------------------------------------------
//  channel | dir | carries                              | accepted on
//  i_cmd   | in  | action, motor, capture_time          | valid && ready
//  o_res   | out | status, speed                        | valid && ready
//  i_cfg   | in  | speed_scale write data               | valid && ready
//
//  A second capture with non-zero period runs the restoring divider, one
//  quotient bit per cycle; input is held off meanwhile.
//  Any other event, zero period included, is written into the result register when taken.
//  A new event is taken while the previous result drains in the same cycle.
//  Reset (sync, active low) clears all channel flags and the scale register.
//  i_cfg is always ready.
// ----------------------------------------------------------------------------
module dual_period_tachometer #(
    parameter int STAMP_BITS = 16,
    parameter int SPEED_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dpt_in_if.sink    i_cmd,
    dpt_out_if.source o_res,
    dpt_cfg_if.sink   i_cfg
);
    import dpt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    dpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dpt_datapath #(
        .STAMP_BITS (STAMP_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_cmd.action),
        .i_motor        (i_cmd.motor),
        .i_capture_time (i_cmd.capture_time),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_status       (o_res.status),
        .o_speed        (o_res.speed)
    );

endmodule

// ===== hw/rtl/dpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_checker
// Port-level checks on the tachometer, bound to the top level.
// ----------------------------------------------------------------------------
module dpt_checker #(
    parameter int SPEED_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [1:0]            i_out_status,
    input logic [SPEED_BITS-1:0] i_out_speed
);
    import dpt_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_status) && $stable(i_out_speed))
        else $error("result changed while stalled");

    // a pending result is never overwritten by a new transaction
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("input taken while result stalled");

    // only a successful speed read carries a speed, and it leaves the channel stopped
    a_speed_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_speed != '0) |-> i_out_status == ST_STOPPED)
        else $error("non-zero speed with channel not stopped");

    // every result follows an accepted transaction
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready) || $past(i_in_valid))
        else $error("result without a transaction");

endmodule

bind dual_period_tachometer dpt_checker #(
    .SPEED_BITS (SPEED_BITS)
) u_dpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.status),
    .i_out_speed  (o_res.speed)
);
